/* rtl/afpi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// afpi_pkg - shared definitions for the adaptive force PI controller
// Register indexes, gain width and default gain values.
// ============================================================================
package afpi_pkg;

    // Gain registers are unsigned fixed point, 31 bits wide
    localparam int GAIN_W = 31;

    // Window sums are 64-bit unsigned
    localparam int SUM_W = 64;

    // Default gains: proportional 370.0, integral 1147 counts at 16 fraction bits
    localparam int KP_DEFAULT_UNITS = 370;
    localparam int KI_DEFAULT_Q16   = 1147;
    localparam int REF_FRAC         = 16;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_PROPORTIONAL_GAIN = 1'b0,
        REG_INTEGRAL_GAIN     = 1'b1
    } cfg_addr_t;

endpackage
`default_nettype wire

/* rtl/adaptive_force_pi_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// adaptive_force_pi_controller - force loop PI controller with adaptive gain
// Squared error/target window sums, gain ratio by long division, ratio-scaled
// force setpoint and an incremental PI velocity update, all on one shared
// shift-add multiplier and one shared restoring divider.
// ============================================================================
//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: pos meas, pos target, force
//          |           |                    |   meas, force target; s_tuser flags
//  m_      | out       | m_tvalid/m_tready  | m_tdata: pos cmd, force cmd, vel cmd,
//          |           |                    |   relative error; m_tuser flags
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wr_data (gains)
//
//  A window restart (restart_window together with report_error) adds a ratio
//  division, skipped when the ratio clamps to one, and a relative error request
//  adds a quotient division. All five products go through the one shift-add
//  multiplier, which works one bit per cycle.
//  s_tready is high only while idle; the result waits in the output register
//  until m_tready. Reset (synchronous, aresetn low) clears sums, ratio,
//  velocity and restores the default gains.
// ============================================================================
module adaptive_force_pi_controller #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire  logic                                     aclk,
    input  wire  logic                                     aresetn,
    input  wire  logic                                     s_tvalid,
    output logic                                           s_tready,
    // [W-1:0] position_measure, position_target, force_measure, force_target
    input  wire  logic [((4*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
    // [0] report_error, [1] restart_window
    input  wire  logic [1:0]                               s_tuser,
    output logic                                           m_tvalid,
    input  wire  logic                                     m_tready,
    // [W-1:0] position_command, force_command, velocity_command, relative_error
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]              m_tdata,
    // [0] relative_error_valid, [1] divide_by_zero
    output logic [1:0]                                     m_tuser,
    input  wire  logic                                     cfg_wr_en,
    input  wire  afpi_pkg::cfg_addr_t                      cfg_addr,
    input  wire  logic [afpi_pkg::GAIN_W-1:0]              cfg_wr_data
);
    import afpi_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int TDW = ((4*W+7)/8)*8;
    localparam int MW  = (W+1 > GAIN_W) ? W+1 : GAIN_W;
    localparam int PW  = 2*MW;
    localparam int QW  = W+F;
    localparam int CW  = $clog2((QW > MW) ? QW : MW);

    localparam logic [63:0] KP_FULL  = 64'(KP_DEFAULT_UNITS) << F;
    localparam logic [63:0] GAIN_MAX = (64'd1 << GAIN_W) - 64'd1;
    localparam logic [GAIN_W-1:0] KP_RESET =
        GAIN_W'((KP_FULL > GAIN_MAX) ? GAIN_MAX : KP_FULL);
    localparam logic [GAIN_W-1:0] KI_RESET =
        GAIN_W'(((64'(KI_DEFAULT_Q16) << F) + (64'd1 << (REF_FRAC-1))) >> REF_FRAC);

    localparam logic signed [W-1:0]   SMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]   SMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W+1:0]   SMAX_X = (W+2)'(SMAX);
    localparam logic signed [W+1:0]   SMIN_X = (W+2)'(SMIN);
    localparam logic [W-1:0]          LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]          LIM_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [F:0]            RATIO_ONE = {1'b1, {F{1'b0}}};
    localparam logic [PW:0]           RND = (PW+1)'((64'd1 << F) - 64'd1);

    typedef enum logic [4:0] {
        S_IDLE, S_SQE_LOAD, S_SQE_RUN, S_SQE_DONE, S_SQT_RUN, S_SQT_DONE,
        S_RATIO, S_DIV_RATIO, S_REL, S_DIV_REL, S_FCMD_RUN, S_FCMD_DONE,
        S_P_LOAD, S_P_RUN, S_P_DONE, S_I_RUN, S_I_DONE, S_OUT
    } state_t;

    // magnitude of a signed value, fits MW bits for all operands here
    function automatic logic [MW-1:0] mag_f(input logic signed [MW:0] v);
        logic [MW:0] u;
        u = v[MW] ? -v : v;
        return u[MW-1:0];
    endfunction

    // saturate to W bits
    function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
        logic signed [W-1:0] r;
        if (v > SMAX_X) begin
            r = SMAX;
        end else if (v < SMIN_X) begin
            r = SMIN;
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    state_t                  state_reg;
    logic [CW-1:0]           cnt_reg;
    logic signed [W-1:0]     pt_reg, fm_reg, ft_reg, perr_reg;
    logic                    report_reg, restart_reg;
    logic [SUM_W-1:0]        esum_reg, tsum_reg;
    logic [F:0]              ratio_reg;
    logic [GAIN_W-1:0]       kp_reg, ki_reg;
    logic signed [W-1:0]     vel_reg, prev_fe_reg, fe_reg, fcmd_reg, pterm_reg, rel_reg;
    logic                    rel_valid_reg, dz_reg, m_tvalid_reg;
    logic [MW-1:0]           mul_a_reg;
    logic [PW:0]             prod_reg;
    logic                    mneg_reg;
    logic [SUM_W-1:0]        rem_reg, den_reg;
    logic [QW-1:0]           dq_reg;

    // input fields
    logic signed [W-1:0] in_pm, in_pt, in_fm, in_ft, perr_next;
    assign in_pm = s_tdata[W-1:0];
    assign in_pt = s_tdata[2*W-1:W];
    assign in_fm = s_tdata[3*W-1:2*W];
    assign in_ft = s_tdata[4*W-1:3*W];
    assign perr_next = sat_w((W+2)'(in_pm) - (W+2)'(in_pt));

    // operand magnitudes
    logic [MW-1:0]       perr_mag, pt_mag, ft_mag, fe_mag, dfe_mag;
    logic signed [MW:0]  dfe;
    assign perr_mag = mag_f((MW+1)'(perr_reg));
    assign pt_mag   = mag_f((MW+1)'(pt_reg));
    assign ft_mag   = mag_f((MW+1)'(ft_reg));
    assign fe_mag   = mag_f((MW+1)'(fe_reg));
    assign dfe      = (MW+1)'(fe_reg) - (MW+1)'(prev_fe_reg);
    assign dfe_mag  = mag_f(dfe);

    // shared shift-add multiplier step
    logic [MW:0] mul_sum;
    logic [PW:0] prod_step;
    assign mul_sum   = {1'b0, prod_reg[PW-1:MW]} + (prod_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign prod_step = {mul_sum, prod_reg[MW-1:0]} >> 1;

    // signed product scaling with floor and saturation
    logic [PW:0]         ms_rnd, ms_sh;
    logic [W-1:0]        ms_lim, ms_mag;
    logic signed [W-1:0] ms_res;
    assign ms_rnd = prod_reg + (mneg_reg ? RND : '0);
    assign ms_sh  = ms_rnd >> F;
    assign ms_lim = mneg_reg ? LIM_NEG : LIM_POS;
    assign ms_mag = (ms_sh > (PW+1)'(ms_lim)) ? ms_lim : ms_sh[W-1:0];
    assign ms_res = mneg_reg ? -ms_mag : ms_mag;

    // square scaling and saturating sum
    logic [PW+63:0]   sq_x;
    logic [SUM_W-1:0] sq_val, acc_sel, sum_sat;
    logic [SUM_W:0]   sum_full;
    assign sq_x     = (PW+64)'(prod_reg[PW-1:0] >> F);
    assign sq_val   = (|sq_x[PW+63:64]) ? '1 : sq_x[63:0];
    assign acc_sel  = (state_reg == S_SQE_DONE) ? esum_reg : tsum_reg;
    assign sum_full = {1'b0, acc_sel} + {1'b0, sq_val};
    assign sum_sat  = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];

    // shared restoring divider step
    logic [SUM_W:0]   div_t, div_d;
    logic             div_ge;
    logic [SUM_W-1:0] rem_step;
    logic [QW-1:0]    dq_step;
    assign div_t    = {rem_reg, dq_reg[QW-1]};
    assign div_d    = div_t - {1'b0, den_reg};
    assign div_ge   = div_t >= {1'b0, den_reg};
    assign rem_step = div_ge ? div_d[SUM_W-1:0] : div_t[SUM_W-1:0];
    assign dq_step  = {dq_reg[QW-2:0], div_ge};

    // relative error from the finished quotient
    logic                rel_neg;
    logic [W-1:0]        rel_lim, rel_mag;
    logic signed [W-1:0] rel_res;
    assign rel_neg = perr_reg[W-1] ^ pt_reg[W-1];
    assign rel_lim = rel_neg ? LIM_NEG : LIM_POS;
    assign rel_mag = (dq_step > QW'(rel_lim)) ? rel_lim : dq_step[W-1:0];
    assign rel_res = rel_neg ? -rel_mag : rel_mag;

    // force error and velocity update
    logic signed [W-1:0] fe_next, vel_next;
    assign fe_next  = sat_w((W+2)'(ms_res) - (W+2)'(fm_reg));
    assign vel_next = sat_w((W+2)'(vel_reg) + (W+2)'(pterm_reg) + (W+2)'(ms_res));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            kp_reg       <= KP_RESET;
            ki_reg       <= KI_RESET;
            esum_reg     <= '0;
            tsum_reg     <= '0;
            ratio_reg    <= '0;
            vel_reg      <= '0;
            prev_fe_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_PROPORTIONAL_GAIN: kp_reg <= cfg_wr_data;
                    REG_INTEGRAL_GAIN:     ki_reg <= cfg_wr_data;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        pt_reg      <= in_pt;
                        fm_reg      <= in_fm;
                        ft_reg      <= in_ft;
                        perr_reg    <= perr_next;
                        report_reg  <= s_tuser[0];
                        restart_reg <= s_tuser[1];
                        state_reg   <= S_SQE_LOAD;
                    end
                end
                S_SQE_LOAD: begin
                    mul_a_reg <= perr_mag;
                    prod_reg  <= (PW+1)'(perr_mag);
                    mneg_reg  <= 1'b0;
                    cnt_reg   <= CW'(MW-1);
                    state_reg <= S_SQE_RUN;
                end
                S_SQE_RUN: begin
                    prod_reg <= prod_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_SQE_DONE;
                    end
                end
                S_SQE_DONE: begin
                    esum_reg  <= sum_sat;
                    mul_a_reg <= pt_mag;
                    prod_reg  <= (PW+1)'(pt_mag);
                    cnt_reg   <= CW'(MW-1);
                    state_reg <= S_SQT_RUN;
                end
                S_SQT_RUN: begin
                    prod_reg <= prod_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_SQT_DONE;
                    end
                end
                S_SQT_DONE: begin
                    tsum_reg  <= sum_sat;
                    state_reg <= (report_reg && restart_reg) ? S_RATIO : S_REL;
                end
                // window restart: ratio = esum / tsum, clamped to one
                S_RATIO: begin
                    esum_reg <= '0;
                    tsum_reg <= '0;
                    if (tsum_reg == '0 || esum_reg >= tsum_reg) begin
                        ratio_reg <= RATIO_ONE;
                        state_reg <= S_REL;
                    end else begin
                        rem_reg   <= esum_reg;
                        dq_reg    <= '0;
                        den_reg   <= tsum_reg;
                        cnt_reg   <= CW'(F-1);
                        state_reg <= S_DIV_RATIO;
                    end
                end
                S_DIV_RATIO: begin
                    rem_reg <= rem_step;
                    dq_reg  <= dq_step;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        ratio_reg <= {1'b0, dq_step[F-1:0]};
                        state_reg <= S_REL;
                    end
                end
                S_REL: begin
                    rel_reg       <= '0;
                    rel_valid_reg <= 1'b0;
                    dz_reg        <= 1'b0;
                    if (report_reg && pt_reg != '0) begin
                        rem_reg   <= '0;
                        dq_reg    <= {perr_mag[W-1:0], {F{1'b0}}};
                        den_reg   <= SUM_W'(pt_mag);
                        cnt_reg   <= CW'(QW-1);
                        state_reg <= S_DIV_REL;
                    end else begin
                        dz_reg    <= report_reg;
                        mul_a_reg <= MW'(ratio_reg);
                        prod_reg  <= (PW+1)'(ft_mag);
                        mneg_reg  <= ft_reg[W-1];
                        cnt_reg   <= CW'(MW-1);
                        state_reg <= S_FCMD_RUN;
                    end
                end
                S_DIV_REL: begin
                    rem_reg <= rem_step;
                    dq_reg  <= dq_step;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        rel_reg       <= rel_res;
                        rel_valid_reg <= 1'b1;
                        mul_a_reg     <= MW'(ratio_reg);
                        prod_reg      <= (PW+1)'(ft_mag);
                        mneg_reg      <= ft_reg[W-1];
                        cnt_reg       <= CW'(MW-1);
                        state_reg     <= S_FCMD_RUN;
                    end
                end
                S_FCMD_RUN: begin
                    prod_reg <= prod_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_FCMD_DONE;
                    end
                end
                S_FCMD_DONE: begin
                    fcmd_reg  <= ms_res;
                    fe_reg    <= fe_next;
                    state_reg <= S_P_LOAD;
                end
                S_P_LOAD: begin
                    mul_a_reg <= MW'(kp_reg);
                    prod_reg  <= (PW+1)'(dfe_mag);
                    mneg_reg  <= dfe[MW];
                    cnt_reg   <= CW'(MW-1);
                    state_reg <= S_P_RUN;
                end
                S_P_RUN: begin
                    prod_reg <= prod_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_P_DONE;
                    end
                end
                S_P_DONE: begin
                    pterm_reg <= ms_res;
                    mul_a_reg <= MW'(ki_reg);
                    prod_reg  <= (PW+1)'(fe_mag);
                    mneg_reg  <= fe_reg[W-1];
                    cnt_reg   <= CW'(MW-1);
                    state_reg <= S_I_RUN;
                end
                S_I_RUN: begin
                    prod_reg <= prod_step;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_I_DONE;
                    end
                end
                S_I_DONE: begin
                    vel_reg      <= vel_next;
                    prev_fe_reg  <= fe_reg;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDW'({rel_reg, vel_reg, fcmd_reg, pt_reg});
    assign m_tuser  = {dz_reg, rel_valid_reg};

endmodule
`default_nettype wire

/* rtl/afpi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// afpi_checker - port-level checks for the adaptive force PI controller
// Watches the stream handshakes and result flags; bound to the top level.
// ============================================================================
module afpi_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]    m_tdata,
    input wire logic [1:0]                           m_tuser
);
    // never takes a new tick while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // an accepted tick keeps the input closed in the next cycle
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after transfer");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // valid relative error and divide by zero are exclusive
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("relative error valid and divide by zero together");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind adaptive_force_pi_controller afpi_checker #(.DATA_WIDTH(DATA_WIDTH)) u_afpi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
